// ----- hw/rtl/fvn_pkg.sv -----
// fvn_pkg: shared constants for the fractal value noise block
// depends on nothing; imported by fractal_value_noise
`default_nettype none

package fvn_pkg;

   localparam int COORD_W             = 24;
   localparam int CSR_ADDR_W          = 2;
   localparam int CSR_DATA_W          = 32;

   localparam int DEF_COORD_FRAC_BITS = 12;
   localparam int DEF_FBM_OCTAVES     = 5;
   localparam int DEF_RIDGED_OCTAVES  = 6;
   localparam int DEF_VALUE_BITS      = 24;

   localparam logic [CSR_ADDR_W-1:0] CSR_NOISE_SEED = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_NOISE_KIND = 2'd1;

   localparam logic [31:0] HASH_K1     = 32'd374761393;
   localparam logic [31:0] HASH_K2     = 32'd668265263;
   localparam logic [31:0] HASH_K3     = 32'd1274126177;
   localparam logic [31:0] FBM_STEP    = 32'd131;
   localparam logic [31:0] RIDGED_STEP = 32'd197;

endpackage

`default_nettype wire

// ----- hw/rtl/fractal_value_noise.sv -----
// fractal_value_noise: pipelined fractal value noise, fbm or ridged multifractal
// depends on fvn_pkg
`default_nettype none

// One coordinate pair enters per cycle and one noise sample leaves per cycle.
// Every octave has its own lane of hash, smoothstep and bilinear blend hardware,
// so the sample rate does not depend on the octave count. The pipeline holds
// thirteen stages of hashing, smoothstep, blending, ridge fold and weighted sum,
// then a reciprocal multiply for the normalising divide and a result register.
// Back-pressure on rsp_ready stalls only the stages that hold data;
// empty stages keep filling. Write noise_seed and noise_kind only while the
// pipeline is empty.
module fractal_value_noise #(
   parameter int COORD_FRAC_BITS = fvn_pkg::DEF_COORD_FRAC_BITS,
   parameter int FBM_OCTAVES     = fvn_pkg::DEF_FBM_OCTAVES,
   parameter int RIDGED_OCTAVES  = fvn_pkg::DEF_RIDGED_OCTAVES,
   parameter int VALUE_BITS      = fvn_pkg::DEF_VALUE_BITS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wr_en,
   input  wire logic [fvn_pkg::CSR_ADDR_W-1:0]       csr_index,
   input  wire logic [fvn_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [fvn_pkg::COORD_W-1:0]   req_x_coord,
   input  wire logic signed [fvn_pkg::COORD_W-1:0]   req_y_coord,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [VALUE_BITS-1:0]                     rsp_noise_value
);
   import fvn_pkg::*;

   localparam int F       = COORD_FRAC_BITS;
   localparam int V       = VALUE_BITS;
   localparam int NL      = (FBM_OCTAVES > RIDGED_OCTAVES) ? FBM_OCTAVES : RIDGED_OCTAVES;
   localparam int SW      = V + NL;
   localparam int NS      = 15;
   localparam int RW      = SW + 2;
   localparam int PW      = SW + RW;
   localparam int K_FBM   = SW + FBM_OCTAVES;
   localparam int K_RDG   = SW + RIDGED_OCTAVES;

   localparam logic [F:0]   ONE_F     = (F+1)'(1) << F;
   localparam logic [F+1:0] THREE_ONE = (F+2)'(3) << F;
   localparam logic [V-1:0] VMAX      = {V{1'b1}};
   localparam logic [SW-1:0] DIV_FBM  = SW'((1 << FBM_OCTAVES) - 1);
   localparam logic [SW-1:0] DIV_RDG  = SW'((1 << RIDGED_OCTAVES) - 1);

   localparam longint unsigned DL_FBM = (64'd1 << FBM_OCTAVES) - 64'd1;
   localparam longint unsigned DL_RDG = (64'd1 << RIDGED_OCTAVES) - 64'd1;
   localparam logic [RW-1:0] RECIP_FBM =
      RW'(((64'd1 << K_FBM) + DL_FBM - 64'd1) / DL_FBM);
   localparam logic [RW-1:0] RECIP_RDG =
      RW'(((64'd1 << K_RDG) + DL_RDG - 64'd1) / DL_RDG);

   // configuration registers
   logic [31:0] csr_seed_ff;
   logic        csr_kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_seed_ff <= '0;
         csr_kind_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_NOISE_SEED: csr_seed_ff <= csr_wdata[31:0];
            CSR_NOISE_KIND: csr_kind_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // valid chain and per-stage advance
   logic [NS-1:0] vld_ff;
   logic [NS:0]   adv;

   assign adv[NS] = rsp_ready;
   for (genvar k = 0; k < NS; k++) begin : g_adv
      assign adv[k] = !vld_ff[k] || adv[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= req_valid;
         for (int k = 1; k < NS; k++) begin
            if (adv[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = vld_ff[NS-1];

   logic [SW-1:0] divisor;
   assign divisor = csr_kind_ff ? DIV_RDG : DIV_FBM;

   // stage 1: lattice cell and fraction per octave
   logic [31:0]  s1_cx_ff [NL];
   logic [31:0]  s1_cy_ff [NL];
   logic [F-1:0] s1_fx_ff [NL];
   logic [F-1:0] s1_fy_ff [NL];
   logic [31:0]  s1_cx_in [NL];
   logic [31:0]  s1_cy_in [NL];
   logic [F-1:0] s1_fx_in [NL];
   logic [F-1:0] s1_fy_in [NL];

   always_comb begin
      logic signed [31:0] xe;
      logic signed [31:0] ye;
      logic signed [31:0] sx;
      logic signed [31:0] sy;
      xe = 32'(req_x_coord);
      ye = 32'(req_y_coord);
      for (int o = 0; o < NL; o++) begin
         sx = xe <<< o;
         sy = ye <<< o;
         s1_cx_in[o] = 32'(sx >>> F);
         s1_cy_in[o] = 32'(sy >>> F);
         s1_fx_in[o] = sx[F-1:0];
         s1_fy_in[o] = sy[F-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_cx_ff <= s1_cx_in;
         s1_cy_ff <= s1_cy_in;
         s1_fx_ff <= s1_fx_in;
         s1_fy_ff <= s1_fy_in;
      end
   end

   // stage 2: first hash products, fraction squares
   logic [31:0]    s2_px_ff  [NL];
   logic [31:0]    s2_py_ff  [NL];
   logic [2*F-1:0] s2_f2x_ff [NL];
   logic [2*F-1:0] s2_f2y_ff [NL];
   logic [F+1:0]   s2_tx_ff  [NL];
   logic [F+1:0]   s2_ty_ff  [NL];

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         for (int o = 0; o < NL; o++) begin
            s2_px_ff[o]  <= s1_cx_ff[o] * HASH_K1;
            s2_py_ff[o]  <= s1_cy_ff[o] * HASH_K2;
            s2_f2x_ff[o] <= (2*F)'(s1_fx_ff[o]) * (2*F)'(s1_fx_ff[o]);
            s2_f2y_ff[o] <= (2*F)'(s1_fy_ff[o]) * (2*F)'(s1_fy_ff[o]);
            s2_tx_ff[o]  <= THREE_ONE - (F+2)'({s1_fx_ff[o], 1'b0});
            s2_ty_ff[o]  <= THREE_ONE - (F+2)'({s1_fy_ff[o], 1'b0});
         end
      end
   end

   // stage 3: corner hash mixing, smoothstep partial products
   logic [31:0]    s3_h_ff   [NL][4];
   logic [2*F+1:0] s3_plx_ff [NL];
   logic [2*F+1:0] s3_phx_ff [NL];
   logic [2*F+1:0] s3_ply_ff [NL];
   logic [2*F+1:0] s3_phy_ff [NL];
   logic [31:0]    s3_h_in   [NL][4];

   always_comb begin
      logic [31:0] seed_o;
      logic [31:0] step;
      logic [31:0] hx [2];
      logic [31:0] hy [2];
      logic [31:0] h;
      step = csr_kind_ff ? RIDGED_STEP : FBM_STEP;
      for (int o = 0; o < NL; o++) begin
         seed_o = csr_seed_ff + 32'(o) * step;
         hx[0] = s2_px_ff[o];
         hx[1] = s2_px_ff[o] + HASH_K1;
         hy[0] = s2_py_ff[o];
         hy[1] = s2_py_ff[o] + HASH_K2;
         for (int c = 0; c < 4; c++) begin
            h = (hx[c % 2] + hy[c / 2]) ^ seed_o;
            s3_h_in[o][c] = h ^ (h >> 13);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s3_h_ff <= s3_h_in;
         for (int o = 0; o < NL; o++) begin
            s3_plx_ff[o] <= (2*F+2)'(s2_f2x_ff[o][F-1:0]) * (2*F+2)'(s2_tx_ff[o]);
            s3_phx_ff[o] <= (2*F+2)'(s2_f2x_ff[o][2*F-1:F]) * (2*F+2)'(s2_tx_ff[o]);
            s3_ply_ff[o] <= (2*F+2)'(s2_f2y_ff[o][F-1:0]) * (2*F+2)'(s2_ty_ff[o]);
            s3_phy_ff[o] <= (2*F+2)'(s2_f2y_ff[o][2*F-1:F]) * (2*F+2)'(s2_ty_ff[o]);
         end
      end
   end

   // stage 4: final hash product, smoothstep weights
   logic [31:0] s4_m_ff  [NL][4];
   logic [F:0]  s4_wx_ff [NL];
   logic [F:0]  s4_wy_ff [NL];
   logic [F:0]  s4_wx_in [NL];
   logic [F:0]  s4_wy_in [NL];

   always_comb begin
      logic [3*F+1:0] tx;
      logic [3*F+1:0] ty;
      for (int o = 0; o < NL; o++) begin
         tx = ((3*F+2)'(s3_phx_ff[o]) << F) + (3*F+2)'(s3_plx_ff[o]);
         ty = ((3*F+2)'(s3_phy_ff[o]) << F) + (3*F+2)'(s3_ply_ff[o]);
         s4_wx_in[o] = tx[3*F:2*F];
         s4_wy_in[o] = ty[3*F:2*F];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         for (int o = 0; o < NL; o++) begin
            for (int c = 0; c < 4; c++) begin
               s4_m_ff[o][c] <= s3_h_ff[o][c] * HASH_K3;
            end
         end
         s4_wx_ff <= s4_wx_in;
         s4_wy_ff <= s4_wy_in;
      end
   end

   // stage 5: corner values
   logic [V-1:0] s5_val_ff [NL][4];
   logic [F:0]   s5_wx_ff  [NL];
   logic [F:0]   s5_wy_ff  [NL];
   logic [V-1:0] s5_val_in [NL][4];

   always_comb begin
      logic [31:0] hv;
      for (int o = 0; o < NL; o++) begin
         for (int c = 0; c < 4; c++) begin
            hv = s4_m_ff[o][c] ^ (s4_m_ff[o][c] >> 16);
            s5_val_in[o][c] = hv[23 -: V];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s5_val_ff <= s5_val_in;
         s5_wx_ff  <= s4_wx_ff;
         s5_wy_ff  <= s4_wy_ff;
      end
   end

   // stage 6: horizontal blend products
   logic [V+F:0] s6_p_ff  [NL][4];
   logic [F:0]   s6_wy_ff [NL];

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         for (int o = 0; o < NL; o++) begin
            for (int c = 0; c < 4; c++) begin
               s6_p_ff[o][c] <= (V+F+1)'(s5_val_ff[o][c]) *
                                (V+F+1)'((c % 2 == 0) ? (ONE_F - s5_wx_ff[o]) : s5_wx_ff[o]);
            end
         end
         s6_wy_ff <= s5_wy_ff;
      end
   end

   // stage 7: top and bottom rows
   logic [V-1:0] s7_top_ff [NL];
   logic [V-1:0] s7_bot_ff [NL];
   logic [F:0]   s7_wy_ff  [NL];

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         for (int o = 0; o < NL; o++) begin
            s7_top_ff[o] <= V'((s6_p_ff[o][0] + s6_p_ff[o][1]) >> F);
            s7_bot_ff[o] <= V'((s6_p_ff[o][2] + s6_p_ff[o][3]) >> F);
         end
         s7_wy_ff <= s6_wy_ff;
      end
   end

   // stage 8: vertical blend products
   logic [V+F:0] s8_pt_ff [NL];
   logic [V+F:0] s8_pb_ff [NL];

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         for (int o = 0; o < NL; o++) begin
            s8_pt_ff[o] <= (V+F+1)'(s7_top_ff[o]) * (V+F+1)'(ONE_F - s7_wy_ff[o]);
            s8_pb_ff[o] <= (V+F+1)'(s7_bot_ff[o]) * (V+F+1)'(s7_wy_ff[o]);
         end
      end
   end

   // stage 9: octave sample and ridge fold
   logic [V-1:0] s9_n_ff [NL];
   logic [V-1:0] s9_r_ff [NL];
   logic [V-1:0] s9_n_in [NL];
   logic [V-1:0] s9_r_in [NL];

   always_comb begin
      logic [V:0] twice;
      logic [V:0] dev;
      for (int o = 0; o < NL; o++) begin
         s9_n_in[o] = V'((s8_pt_ff[o] + s8_pb_ff[o]) >> F);
         twice = {s9_n_in[o], 1'b0};
         if (twice >= (V+1)'(VMAX)) begin
            dev = twice - (V+1)'(VMAX);
         end else begin
            dev = (V+1)'(VMAX) - twice;
         end
         s9_r_in[o] = VMAX - V'(dev);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         s9_n_ff <= s9_n_in;
         s9_r_ff <= s9_r_in;
      end
   end

   // stage 10: ridge square
   logic [V-1:0]   s10_n_ff  [NL];
   logic [2*V-1:0] s10_rr_ff [NL];

   always_ff @(posedge clock) begin
      if (adv[9]) begin
         for (int o = 0; o < NL; o++) begin
            s10_rr_ff[o] <= (2*V)'(s9_r_ff[o]) * (2*V)'(s9_r_ff[o]);
         end
         s10_n_ff <= s9_n_ff;
      end
   end

   // stage 11: ridged mode: rounded divide of the ridge square by full scale; fbm: sample passes through
   logic [V-1:0] s11_n_ff [NL];
   logic [V-1:0] s11_n_in [NL];

   always_comb begin
      logic [2*V:0] x;
      logic [V:0]   q0;
      logic [V+1:0] r1;
      logic [V+1:0] q;
      for (int o = 0; o < NL; o++) begin
         x  = (2*V+1)'(s10_rr_ff[o]) + (2*V+1)'(VMAX >> 1);
         q0 = x[2*V:V];
         r1 = (V+2)'(x[V-1:0]) + (V+2)'(q0);
         q  = (V+2)'(q0) + (V+2)'(r1 >= (V+2)'(VMAX)) +
              (V+2)'(r1 >= ((V+2)'(VMAX) << 1));
         s11_n_in[o] = csr_kind_ff ? V'(q) : s10_n_ff[o];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[10]) s11_n_ff <= s11_n_in;
   end

   // stage 12: weighted partial sums
   logic [SW-1:0] s12_lo_ff;
   logic [SW-1:0] s12_hi_ff;
   logic [SW-1:0] s12_lo_in;
   logic [SW-1:0] s12_hi_in;

   always_comb begin
      logic [SW-1:0] term;
      s12_lo_in = '0;
      s12_hi_in = '0;
      for (int o = 0; o < NL; o++) begin
         term = '0;
         if (csr_kind_ff) begin
            if (o < RIDGED_OCTAVES) term = SW'(s11_n_ff[o]) << (RIDGED_OCTAVES - 1 - o);
         end else begin
            if (o < FBM_OCTAVES) term = SW'(s11_n_ff[o]) << (FBM_OCTAVES - 1 - o);
         end
         if (o < 4) begin
            s12_lo_in = s12_lo_in + term;
         end else begin
            s12_hi_in = s12_hi_in + term;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[11]) begin
         s12_lo_ff <= s12_lo_in;
         s12_hi_ff <= s12_hi_in;
      end
   end

   // stage 13: total with rounding bias
   logic [SW-1:0] s13_x_ff;

   always_ff @(posedge clock) begin
      if (adv[12]) s13_x_ff <= s12_lo_ff + s12_hi_ff + (divisor >> 1);
   end

   // stage 14: reciprocal multiply for the divide by the weight total
   logic [RW-1:0] recip;
   logic [PW-1:0] s14_p_ff;

   assign recip = csr_kind_ff ? RECIP_RDG : RECIP_FBM;

   always_ff @(posedge clock) begin
      if (adv[13]) s14_p_ff <= PW'(s13_x_ff) * PW'(recip);
   end

   // stage 15: quotient
   logic [V-1:0] s15_q_ff;

   always_ff @(posedge clock) begin
      if (adv[14]) s15_q_ff <= csr_kind_ff ? s14_p_ff[K_RDG +: V] : s14_p_ff[K_FBM +: V];
   end

   assign rsp_noise_value = s15_q_ff;

endmodule

`default_nettype wire
